// ===== sv/gdpr_pkg.sv =====
// Shared constants and interface types for the grid duplicate point repair block.
package gdpr_pkg;

  localparam int GRID_SIDE = 64;
  localparam int COORD_W   = 6;                 // grid coordinate bits
  localparam int FRAC_BITS = 8;
  localparam int IN_W      = 24;                // fixed-point input coordinate
  localparam int SCOORD_W  = COORD_W + 4;       // signed candidate coordinate
  localparam int DX_W      = COORD_W + 3;       // signed shell offset
  localparam int RAD_W     = COORD_W + 2;       // shell radius, up to 2*(side-1)+3
  localparam int ROW_W     = GRID_SIDE;
  localparam int IDX_W     = 2;                 // config register index

  localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // request to the occupancy memory
  typedef struct packed {
    logic               clear;
    logic               rd_en;
    logic [COORD_W-1:0] rd_addr;
    logic               wr_en;
    logic [COORD_W-1:0] wr_addr;
  } mem_req_t;

  // current shell candidate
  typedef struct packed {
    logic               live;   // radius still within the search limit
    logic               inb;    // candidate lies inside the grid bounds
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cand_t;

endpackage

// ===== sv/gdpr_occ_mem.sv =====
// Occupancy bitmap: one row of cells per y, row valid bits give the cleared state.
module gdpr_occ_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  gdpr_pkg::mem_req_t          req,
  input  logic [gdpr_pkg::ROW_W-1:0]  wr_data,
  output logic [gdpr_pkg::ROW_W-1:0]  rd_word
);

  logic [gdpr_pkg::ROW_W-1:0]     mem [gdpr_pkg::GRID_SIDE];
  logic [gdpr_pkg::GRID_SIDE-1:0] row_valid;
  logic [gdpr_pkg::ROW_W-1:0]     rdata;
  logic                           rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      row_valid <= '0;
    end else if (req.wr_en) begin
      row_valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (req.rd_en) begin
      rd_valid <= row_valid[req.rd_addr];
    end
  end

  // a row never written since the last clear reads as all free
  assign rd_word = rd_valid ? rdata : '0;

endmodule

// ===== sv/gdpr_shell_gen.sv =====
// Walks Manhattan shell candidates around the rounded cell, one per step.
module gdpr_shell_gen (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          step,
  input  logic [gdpr_pkg::COORD_W-1:0]  cx,
  input  logic [gdpr_pkg::COORD_W-1:0]  cy,
  input  logic [gdpr_pkg::COORD_W-1:0]  w,
  input  logic [gdpr_pkg::COORD_W-1:0]  h,
  output gdpr_pkg::cand_t               cand
);

  logic [gdpr_pkg::RAD_W-1:0]    r;
  logic [gdpr_pkg::RAD_W-1:0]    r_inc;
  logic [gdpr_pkg::RAD_W-1:0]    limit;
  logic [gdpr_pkg::DX_W-1:0]     dx;
  logic                          side;   // 0 lower y, 1 upper y
  logic [gdpr_pkg::RAD_W-1:0]    absdx;
  logic [gdpr_pkg::RAD_W-1:0]    rem;
  logic [gdpr_pkg::SCOORD_W-1:0] sx;
  logic [gdpr_pkg::SCOORD_W-1:0] sy;

  always_comb begin
    absdx = dx[gdpr_pkg::DX_W-1] ? gdpr_pkg::RAD_W'(-dx) : dx[gdpr_pkg::RAD_W-1:0];
    rem   = r - absdx;
    r_inc = r + gdpr_pkg::RAD_W'(1);
    sx    = {{(gdpr_pkg::SCOORD_W-gdpr_pkg::COORD_W){1'b0}}, cx}
          + {{(gdpr_pkg::SCOORD_W-gdpr_pkg::DX_W){dx[gdpr_pkg::DX_W-1]}}, dx};
    if (side) begin
      sy = {{(gdpr_pkg::SCOORD_W-gdpr_pkg::COORD_W){1'b0}}, cy}
         + {{(gdpr_pkg::SCOORD_W-gdpr_pkg::RAD_W){1'b0}}, rem};
    end else begin
      sy = {{(gdpr_pkg::SCOORD_W-gdpr_pkg::COORD_W){1'b0}}, cy}
         - {{(gdpr_pkg::SCOORD_W-gdpr_pkg::RAD_W){1'b0}}, rem};
    end
    cand.live = (r <= limit);
    cand.inb  = !sx[gdpr_pkg::SCOORD_W-1] && !sy[gdpr_pkg::SCOORD_W-1]
             && (sx <= {{(gdpr_pkg::SCOORD_W-gdpr_pkg::COORD_W){1'b0}}, w})
             && (sy <= {{(gdpr_pkg::SCOORD_W-gdpr_pkg::COORD_W){1'b0}}, h});
    cand.x    = sx[gdpr_pkg::COORD_W-1:0];
    cand.y    = sy[gdpr_pkg::COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r     <= '0;
      dx    <= '0;
      side  <= 1'b0;
      limit <= '0;
    end else if (start) begin
      r     <= gdpr_pkg::RAD_W'(1);
      dx    <= '1;
      side  <= 1'b0;
      limit <= gdpr_pkg::RAD_W'(w) + gdpr_pkg::RAD_W'(h) + gdpr_pkg::RAD_W'(2);
    end else if (step) begin
      // the shell tips have a single cell, all others a lower and an upper one
      if (rem == '0 || side) begin
        side <= 1'b0;
        if (dx == {1'b0, r}) begin
          r  <= r_inc;
          dx <= -{1'b0, r_inc};
        end else begin
          dx <= dx + gdpr_pkg::DX_W'(1);
        end
      end else begin
        side <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/grid_duplicate_point_repair.sv =====
// Top level: collision-free grid placement with rounding, shell search and result register.
//
// Places fixed-point points onto a grid of cells 0..grid_width by 0..grid_height.
// Input channel s_*: s_tuser is the opcode (place or clear), s_tdata carries x and y
// with 8 fraction bits. Output channel m_*: one result per request with the assigned
// cell and the moved, failed and sticky any_moved flags. Config channel cfg_*: always
// ready, index 0 writes grid_width, index 1 grid_height, other indexes are ignored.
// A clear request goes straight from idle to the finish state. A place request rounds
// x and y, reads the row of its rounded cell and, if that cell is free, writes it. A
// collision walks shell candidates in order by the shell generator, one occupancy row
// read per in-bounds candidate; a full grid walks all shells up to radius width+height+2.
// The block takes one request at a time; it is ready again once the result sits in
// the output register, so the next request may start while that result waits.
// If the receiver stalls, a finished result holds until the register frees.
// Reset empties the map (row valid bits), clears the sticky flag and sets both
// bounds to 63; no clearing pass is needed.
module grid_duplicate_point_repair (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [47:0]                 s_tdata,   // x_in[23:0], y_in[47:24]
  input  logic                        s_tuser,   // opcode
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // x_out, y_out, moved, failed, any_moved, 0
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gdpr_pkg::IDX_W-1:0]  cfg_index,
  input  logic [5:0]                  cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RNDX   = 3'd1;
  localparam logic [2:0] S_RNDY   = 3'd2;
  localparam logic [2:0] S_CTR    = 3'd3;
  localparam logic [2:0] S_CTRCHK = 3'd4;
  localparam logic [2:0] S_SRCH   = 3'd5;
  localparam logic [2:0] S_WRITE  = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  localparam int CW   = gdpr_pkg::COORD_W;
  localparam int QW   = gdpr_pkg::IN_W + 1;
  localparam int HALF = (1 << gdpr_pkg::FRAC_BITS) >> 1;

  logic [2:0]                    state;
  logic [CW-1:0]                 grid_width;
  logic [CW-1:0]                 grid_height;
  logic [gdpr_pkg::IN_W-1:0]     x_raw;
  logic [gdpr_pkg::IN_W-1:0]     y_raw;
  logic [CW-1:0]                 cx;
  logic [CW-1:0]                 cy;
  logic [CW-1:0]                 rx;
  logic [CW-1:0]                 ry;
  logic                          mv;
  logic                          sticky;
  logic [gdpr_pkg::ROW_W-1:0]    row_word;
  logic [CW-1:0]                 res_x;
  logic [CW-1:0]                 res_y;
  logic                          res_moved;
  logic                          res_failed;
  logic                          res_any;

  logic                          chk_vld;
  logic                          chk_inb;
  logic [CW-1:0]                 chk_x;
  logic [CW-1:0]                 chk_y;

  gdpr_pkg::mem_req_t            mreq;
  logic [gdpr_pkg::ROW_W-1:0]    wr_data;
  logic [gdpr_pkg::ROW_W-1:0]    rd_word;
  gdpr_pkg::cand_t               cand;
  logic                          gen_start;
  logic                          gen_step;

  // shared rounding unit: x in S_RNDX, y in S_RNDY
  logic [gdpr_pkg::IN_W-1:0]     rnd_raw;
  logic [CW-1:0]                 rnd_max;
  logic [QW-1:0]                 rnd_sum;
  logic [QW-1:0]                 rnd_q;
  logic [CW-1:0]                 rnd_out;

  logic                          in_acc;
  logic                          out_free;
  logic                          found;
  logic                          exhausted;

  always_comb begin
    rnd_raw = (state == S_RNDX) ? x_raw : y_raw;
    rnd_max = (state == S_RNDX) ? grid_width : grid_height;
    rnd_sum = {1'b0, rnd_raw} + QW'(HALF);
    rnd_q   = rnd_sum >> gdpr_pkg::FRAC_BITS;
    // negative inputs round to zero or below and clamp to zero
    if (rnd_raw[gdpr_pkg::IN_W-1]) begin
      rnd_out = '0;
    end else if (rnd_q > QW'(rnd_max)) begin
      rnd_out = rnd_max;
    end else begin
      rnd_out = rnd_q[CW-1:0];
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign found     = chk_vld && chk_inb && !rd_word[chk_x];
  assign exhausted = !chk_vld && !cand.live;
  assign gen_start = (state == S_CTRCHK);
  assign gen_step  = (state == S_SRCH) && cand.live && !found;

  always_comb begin
    mreq.clear   = in_acc && (s_tuser == gdpr_pkg::OP_CLEAR);
    mreq.rd_en   = 1'b0;
    mreq.rd_addr = cy;
    mreq.wr_en   = (state == S_WRITE);
    mreq.wr_addr = ry;
    unique case (state)
      S_CTR: begin
        mreq.rd_en = 1'b1;
      end
      S_SRCH: begin
        mreq.rd_en   = cand.live && cand.inb && !found;
        mreq.rd_addr = cand.y;
      end
      default: begin
        mreq.rd_en = 1'b0;
      end
    endcase
    wr_data = row_word | (gdpr_pkg::ROW_W'(1) << rx);
  end

  gdpr_occ_mem u_occ_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .wr_data (wr_data),
    .rd_word (rd_word)
  );

  gdpr_shell_gen u_shell_gen (
    .clk   (clk),
    .rst   (rst),
    .start (gen_start),
    .step  (gen_step),
    .cx    (cx),
    .cy    (cy),
    .w     (grid_width),
    .h     (grid_height),
    .cand  (cand)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 6'd63;
      grid_height <= 6'd63;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gdpr_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        gdpr_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sticky   <= 1'b0;
      chk_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // in S_FIN the output register is reloaded below instead
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            x_raw <= s_tdata[23:0];
            y_raw <= s_tdata[47:24];
            if (s_tuser == gdpr_pkg::OP_CLEAR) begin
              sticky     <= 1'b0;
              res_x      <= '0;
              res_y      <= '0;
              res_moved  <= 1'b0;
              res_failed <= 1'b0;
              res_any    <= 1'b0;
              state      <= S_FIN;
            end else begin
              state <= S_RNDX;
            end
          end
        end
        S_RNDX: begin
          cx    <= rnd_out;
          state <= S_RNDY;
        end
        S_RNDY: begin
          cy    <= rnd_out;
          state <= S_CTR;
        end
        S_CTR: begin
          state <= S_CTRCHK;
        end
        S_CTRCHK: begin
          row_word <= rd_word;
          chk_vld  <= 1'b0;
          if (!rd_word[cx]) begin
            rx    <= cx;
            ry    <= cy;
            mv    <= 1'b0;
            state <= S_WRITE;
          end else begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          // issue stage feeds the check stage one candidate per cycle
          chk_vld <= cand.live && !found;
          chk_inb <= cand.inb;
          chk_x   <= cand.x;
          chk_y   <= cand.y;
          if (found) begin
            row_word <= rd_word;
            rx       <= chk_x;
            ry       <= chk_y;
            mv       <= 1'b1;
            state    <= S_WRITE;
          end else if (exhausted) begin
            res_x      <= '0;
            res_y      <= '0;
            res_moved  <= 1'b0;
            res_failed <= 1'b1;
            res_any    <= sticky;
            state      <= S_FIN;
          end
        end
        S_WRITE: begin
          chk_vld    <= 1'b0;
          res_x      <= rx;
          res_y      <= ry;
          res_moved  <= mv;
          res_failed <= 1'b0;
          res_any    <= mv || sticky;
          if (mv) begin
            sticky <= 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      m_tdata <= {1'b0, res_any, res_failed, res_moved, res_y, res_x};
    end
  end

endmodule

// ===== verif/grid_duplicate_point_repair_tb.sv =====
// Self-checking testbench for grid_duplicate_point_repair: bounds, collisions, clears, full grid.
module grid_duplicate_point_repair_tb;

  localparam int CW = gdpr_pkg::COORD_W;
  localparam logic [gdpr_pkg::IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [gdpr_pkg::IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct {
    logic        op;
    logic [23:0] x;
    logic [23:0] y;
    bit          drain_first;   // hold until every result is back
  } point_req_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          moved;
    logic          failed;
    logic          any_moved;
  } placement_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [gdpr_pkg::IDX_W-1:0] cfg_index = '0;
  logic [5:0]  cfg_data = '0;

  grid_duplicate_point_repair u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [gdpr_pkg::GRID_SIDE-1:0] occupied [gdpr_pkg::GRID_SIDE];
  logic sticky_moved = 1'b0;
  int   bound_x = 63;
  int   bound_y = 63;

  point_req_t point_reqs[$];
  placement_t expected_cells[$];

  int  errors = 0;
  int  n_places = 0, n_clears = 0, n_moved = 0, n_failed = 0, n_cfg = 0;
  int  pause_pct = 0;
  int  stall_pct = 0;
  bit  calm = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;
  point_req_t head;
  placement_t pred;
  placement_t want;

  initial begin
    occupied = '{default: '0};
  end

  function automatic int round_to_cell(logic [23:0] raw, int lim);
    int v, mag, r;
    v = {{8{raw[23]}}, raw};
    mag = (v < 0) ? -v : v;
    r = (mag + (1 << (gdpr_pkg::FRAC_BITS - 1))) >>> gdpr_pkg::FRAC_BITS;
    if (v < 0) r = -r;
    if (r < 0) r = 0;
    if (r > lim) r = lim;
    return r;
  endfunction

  function automatic bit cell_free(int x, int y);
    if (x < 0 || y < 0 || x > bound_x || y > bound_y) return 1'b0;
    return !occupied[y[CW-1:0]][x[CW-1:0]];
  endfunction

  // expected result of one request; updates the occupancy copy
  function automatic placement_t place_point(logic op, logic [23:0] xr, logic [23:0] yr);
    placement_t res;
    int cx, cy, r, dx, rem, px, py;
    bit found;
    res = '0;
    if (op == gdpr_pkg::OP_CLEAR) begin
      occupied = '{default: '0};
      sticky_moved = 1'b0;
      return res;
    end
    cx = round_to_cell(xr, bound_x);
    cy = round_to_cell(yr, bound_y);
    if (!occupied[cy[CW-1:0]][cx[CW-1:0]]) begin
      occupied[cy[CW-1:0]][cx[CW-1:0]] = 1'b1;
      res.x = CW'(cx);
      res.y = CW'(cy);
      res.any_moved = sticky_moved;
      return res;
    end
    found = 1'b0;
    px = 0;
    py = 0;
    // Manhattan shells; lower y first on each column
    for (r = 1; r <= bound_x + bound_y + 2 && !found; r++) begin
      for (dx = -r; dx <= r && !found; dx++) begin
        rem = r - ((dx < 0) ? -dx : dx);
        px = cx + dx;
        if (rem == 0) begin
          if (cell_free(px, cy)) begin
            py = cy;
            found = 1'b1;
          end
        end else if (cell_free(px, cy - rem)) begin
          py = cy - rem;
          found = 1'b1;
        end else if (cell_free(px, cy + rem)) begin
          py = cy + rem;
          found = 1'b1;
        end
      end
    end
    if (!found) begin
      res.failed = 1'b1;
      res.any_moved = sticky_moved;
      return res;
    end
    occupied[py[CW-1:0]][px[CW-1:0]] = 1'b1;
    sticky_moved = 1'b1;
    res.x = CW'(px);
    res.y = CW'(py);
    res.moved = 1'b1;
    res.any_moved = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    errors++;
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, exp_val, $time);
  endtask

  task automatic append_expected(placement_t item);
    expected_cells.insert(expected_cells.size(), item);
  endtask

  task automatic append_request(point_req_t item);
    point_reqs.insert(point_reqs.size(), item);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pred = place_point(s_tuser, s_tdata[23:0], s_tdata[47:24]);
        append_expected(pred);
        if (s_tuser == gdpr_pkg::OP_CLEAR) n_clears++;
        else n_places++;
        if (pred.moved) n_moved++;
        if (pred.failed) n_failed++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (point_reqs.size() != 0 &&
                     !(point_reqs[0].drain_first &&
                       (expected_cells.size() != 0 || s_tvalid))) begin
          head = point_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {head.y, head.x};
          s_tuser  <= head.op;
          if (!calm && $urandom_range(0, 99) < pause_pct) send_gap = $urandom_range(1, 12);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_cells.size() == 0) begin
          report_mismatch("unexpected result", int'(m_tdata), 0);
        end else begin
          want = expected_cells.pop_front();
          if (m_tdata[5:0] !== want.x)
            report_mismatch("x_out", int'(m_tdata[5:0]), int'(want.x));
          if (m_tdata[11:6] !== want.y)
            report_mismatch("y_out", int'(m_tdata[11:6]), int'(want.y));
          if (m_tdata[12] !== want.moved)
            report_mismatch("moved", int'(m_tdata[12]), int'(want.moved));
          if (m_tdata[13] !== want.failed)
            report_mismatch("failed", int'(m_tdata[13]), int'(want.failed));
          if (m_tdata[14] !== want.any_moved)
            report_mismatch("any_moved", int'(m_tdata[14]), int'(want.any_moved));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 11);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("** grid_duplicate_point_repair: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [gdpr_pkg::IDX_W-1:0] idx, logic [5:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    if (idx == gdpr_pkg::REG_GRID_WIDTH) bound_x = int'(val);
    else if (idx == gdpr_pkg::REG_GRID_HEIGHT) bound_y = int'(val);
  endtask

  task automatic set_bounds(int w, int h);
    write_reg(gdpr_pkg::REG_GRID_WIDTH, 6'(w));
    write_reg(gdpr_pkg::REG_GRID_HEIGHT, 6'(h));
  endtask

  task automatic queue_point(logic op, logic [23:0] x, logic [23:0] y);
    point_req_t p;
    p.op = op;
    p.x = x;
    p.y = y;
    p.drain_first = 1'b0;
    append_request(p);
  endtask

  function automatic logic [23:0] pick_coord(int lim);
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom();
      1: begin
        // exact half: rounding tie
        v = ($urandom_range(0, lim) << gdpr_pkg::FRAC_BITS)
          + (1 << (gdpr_pkg::FRAC_BITS - 1));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom_range(0, (lim + 2) << gdpr_pkg::FRAC_BITS)
                 - (1 << gdpr_pkg::FRAC_BITS);
    endcase
    return v[23:0];
  endfunction

  task automatic queue_random(int n, int win);
    point_req_t p;
    for (int i = 0; i < n; i++) begin
      p.op = ($urandom_range(0, 39) == 0) ? gdpr_pkg::OP_CLEAR : gdpr_pkg::OP_PLACE;
      p.x = pick_coord(win);
      p.y = pick_coord(win);
      p.drain_first = (i == n / 2);
      append_request(p);
    end
  endtask

  task automatic finish_phase();
    while (point_reqs.size() != 0 || s_tvalid || expected_cells.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int w, h;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: corners, rounding ties, clamping, collisions, clears
    pause_pct = 15;
    stall_pct = 5;
    write_reg(REG_SPARE_LO, 6'h2A);
    set_bounds(63, 63);
    queue_point(gdpr_pkg::OP_PLACE, 24'h000000, 24'h000000);
    queue_point(gdpr_pkg::OP_PLACE, 24'h000000, 24'h000000);
    queue_point(gdpr_pkg::OP_PLACE, 24'h00007F, 24'hFFFF81);
    queue_point(gdpr_pkg::OP_PLACE, 24'h7FFFFF, 24'h800000);
    queue_point(gdpr_pkg::OP_PLACE, 24'h800000, 24'h7FFFFF);
    queue_point(gdpr_pkg::OP_PLACE, 24'h7FFFFF, 24'h7FFFFF);
    queue_point(gdpr_pkg::OP_PLACE, 24'h7FFFFF, 24'h7FFFFF);
    queue_point(gdpr_pkg::OP_PLACE, 24'h000080, 24'h000180);
    queue_point(gdpr_pkg::OP_PLACE, 24'hFFFF80, 24'h000280);
    queue_point(gdpr_pkg::OP_PLACE, 24'h001F80, 24'h001F7F);
    for (int i = 0; i < 4; i++) queue_point(gdpr_pkg::OP_PLACE, 24'h001F80, 24'h001F7F);
    queue_point(gdpr_pkg::OP_CLEAR, 24'hFFFFFF, 24'hFFFFFF);
    queue_point(gdpr_pkg::OP_PLACE, 24'h7FFFFF, 24'h000000);
    queue_point(gdpr_pkg::OP_CLEAR, 24'h800000, 24'h000001);
    finish_phase();

    // single-cell grid: second place finds no room
    set_bounds(0, 0);
    write_reg(REG_SPARE_HI, 6'h15);
    queue_point(gdpr_pkg::OP_PLACE, 24'h000500, 24'h000500);
    queue_point(gdpr_pkg::OP_PLACE, 24'h000000, 24'h000000);
    queue_point(gdpr_pkg::OP_CLEAR, 24'h000000, 24'h000000);
    queue_point(gdpr_pkg::OP_PLACE, 24'hFFF000, 24'h7FFFFF);
    finish_phase();

    // random phases over several grid shapes
    pause_pct = 20;
    stall_pct = 8;
    set_bounds(63, 63);
    queue_random(150, 5);
    finish_phase();

    set_bounds(3, 2);
    queue_random(30, 3);
    finish_phase();

    pause_pct = 0;
    stall_pct = 0;
    set_bounds(63, 0);
    queue_random(70, 63);
    finish_phase();

    pause_pct = 30;
    stall_pct = 15;
    set_bounds(0, 63);
    queue_random(70, 63);
    finish_phase();

    set_bounds(7, 7);
    queue_random(80, 7);
    finish_phase();

    for (int k = 0; k < 5; k++) begin
      w = $urandom_range(0, 12);
      h = $urandom_range(0, 12);
      pause_pct = $urandom_range(0, 40);
      stall_pct = $urandom_range(0, 20);
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, 6'($urandom()));
      set_bounds(w, h);
      queue_random(30, $urandom_range(1, 12));
      finish_phase();
    end

    // closing stretch at full speed
    calm = 1'b1;
    set_bounds(63, 63);
    queue_random(50, 6);
    finish_phase();

    $display("covered %0d places, %0d clears, %0d config writes", n_places, n_clears, n_cfg);
    $display("results: %0d moved, %0d grid-full, %0d mismatches", n_moved, n_failed, errors);
    if (errors == 0) $display("** grid_duplicate_point_repair: PASSED **");
    else $display("** grid_duplicate_point_repair: FAILED **");
    $finish;
  end

endmodule
